### hdl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock while out of reset.
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds on the clock after a trigger.
`define PPS_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

### hdl/pps_pkg.sv
// Package for the preemptive priority scheduler: sizes, payload structs, FSM states.
// No dependencies.
package pps_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int TAG_W    = 8;
  localparam int ARR_W    = 16;
  localparam int BURST_W  = 12;
  localparam int URG_W    = 16;
  localparam int TIME_W   = 17;

  typedef struct packed {
    logic [TAG_W-1:0]   job_tag;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [URG_W-1:0]   urgency;
    logic               last_job;
  } job_in_t;

  typedef struct packed {
    logic [TAG_W-1:0]  result_tag;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] response;
    logic              last_result;
  } job_out_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_SERVE = 5'b01000,
    ST_EMIT  = 5'b10000
  } pps_state_t;

endpackage

### hdl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler top level: job store, scan sequencer, result emit.
// Depends on pps_pkg and assert_macros.svh.
//
//  channel | ports                        | handshake
//  --------+------------------------------+--------------------------------
//  input   | start, busy, in_data         | transfer when start && !busy
//  result  | out_valid, out_data          | one-cycle strobe, no back-pressure
//  config  | cfg_we, cfg_wdata            | write when cfg_we
//
// After the final job, every simulated tick (or idle jump) runs a scan: one
// comparator walks the job entries one per cycle, then the chosen job is
// served. Results then stream out one per cycle. busy is high from the final
// load until the last result. Synchronous reset clears counters and flags and
// sets the config register to 1.
`include "assert_macros.svh"

module preemptive_priority_scheduler import pps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  job_in_t  in_data,
  output logic     out_valid,
  output job_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  // job entries
  logic [TAG_W-1:0]   tag_r       [MAX_JOBS];
  logic [ARR_W-1:0]   arr_r       [MAX_JOBS];
  logic [BURST_W-1:0] burst_r     [MAX_JOBS];
  logic [URG_W-1:0]   urg_r       [MAX_JOBS];
  logic [BURST_W-1:0] rem_r       [MAX_JOBS];
  logic [TIME_W-1:0]  first_run_r [MAX_JOBS];
  logic [TIME_W-1:0]  finish_r    [MAX_JOBS];
  logic [MAX_JOBS-1:0] done_r, started_r;

  pps_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  job_count_r, job_count_nxt;
  logic [CNT_W-1:0]  fin_count_r, fin_count_nxt;
  logic [TIME_W-1:0] sim_clk_r, sim_clk_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              lvw_r;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  pick_r, pick_nxt;
  logic [URG_W-1:0]  best_urg_r, best_urg_nxt;
  logic [BURST_W-1:0] best_rem_r, best_rem_nxt;
  logic              best_started_r, best_started_nxt;
  logic [ARR_W-1:0]  min_arr_r, min_arr_nxt;
  logic              out_valid_r;
  job_out_t          out_r;

  logic              accept, room, idx_last, elig, better;
  logic [IDX_W-1:0]  ld_idx;
  logic [TIME_W-1:0] tat;

  assign accept   = start && (state_r == ST_IDLE);
  assign room     = job_count_r < CNT_W'(MAX_JOBS);
  assign ld_idx   = job_count_r[IDX_W-1:0];
  assign idx_last = ({1'b0, idx_r} == (job_count_r - CNT_W'(1)));
  assign elig     = !done_r[idx_r] && ({1'b0, arr_r[idx_r]} <= sim_clk_r);
  assign better   = !found_r || (lvw_r ? (urg_r[idx_r] < best_urg_r)
                                       : (urg_r[idx_r] > best_urg_r));
  assign tat      = finish_r[idx_r] - {1'b0, arr_r[idx_r]};

  always_comb begin
    state_nxt        = state_r;
    job_count_nxt    = job_count_r;
    fin_count_nxt    = fin_count_r;
    sim_clk_nxt      = sim_clk_r;
    idx_nxt          = idx_r;
    found_nxt        = found_r;
    pick_nxt         = pick_r;
    best_urg_nxt     = best_urg_r;
    best_rem_nxt     = best_rem_r;
    best_started_nxt = best_started_r;
    min_arr_nxt      = min_arr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (room) begin
            job_count_nxt = job_count_r + CNT_W'(1);
            if (job_count_r == '0) begin
              fin_count_nxt = CNT_W'(in_data.burst == '0);
            end else if (in_data.burst == '0) begin
              fin_count_nxt = fin_count_r + CNT_W'(1);
            end
          end
          if (in_data.last_job) begin
            state_nxt   = ST_CHECK;
            sim_clk_nxt = '0;
          end
        end
      end
      ST_CHECK: begin
        idx_nxt     = '0;
        found_nxt   = 1'b0;
        min_arr_nxt = '1;
        state_nxt   = (fin_count_r == job_count_r) ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (elig && better) begin
          found_nxt        = 1'b1;
          pick_nxt         = idx_r;
          best_urg_nxt     = urg_r[idx_r];
          best_rem_nxt     = rem_r[idx_r];
          best_started_nxt = started_r[idx_r];
        end
        if (!done_r[idx_r] && (arr_r[idx_r] < min_arr_r)) begin
          min_arr_nxt = arr_r[idx_r];
        end
        if (idx_last) begin
          state_nxt = ST_SERVE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_SERVE: begin
        state_nxt = ST_CHECK;
        if (!found_r) begin
          sim_clk_nxt = {1'b0, min_arr_r};
        end else begin
          sim_clk_nxt = sim_clk_r + TIME_W'(1);
          if (best_rem_r == BURST_W'(1)) begin
            fin_count_nxt = fin_count_r + CNT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (idx_last) begin
          state_nxt     = ST_IDLE;
          job_count_nxt = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_count_r <= '0;
      fin_count_r <= '0;
      sim_clk_r   <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      lvw_r       <= 1'b1;
      out_valid_r <= 1'b0;
      done_r      <= '0;
      started_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      job_count_r <= job_count_nxt;
      fin_count_r <= fin_count_nxt;
      sim_clk_r   <= sim_clk_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= (state_r == ST_EMIT);
      if (cfg_we) begin
        lvw_r <= cfg_wdata;
      end
      if (accept && room) begin
        done_r[ld_idx]    <= (in_data.burst == '0);
        started_r[ld_idx] <= 1'b0;
      end
      if ((state_r == ST_SERVE) && found_r) begin
        started_r[pick_r] <= 1'b1;
        if (best_rem_r == BURST_W'(1)) begin
          done_r[pick_r] <= 1'b1;
        end
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    pick_r         <= pick_nxt;
    best_urg_r     <= best_urg_nxt;
    best_rem_r     <= best_rem_nxt;
    best_started_r <= best_started_nxt;
    min_arr_r      <= min_arr_nxt;
    if (accept && room) begin
      tag_r[ld_idx]   <= in_data.job_tag;
      arr_r[ld_idx]   <= in_data.arrival;
      burst_r[ld_idx] <= in_data.burst;
      urg_r[ld_idx]   <= in_data.urgency;
      rem_r[ld_idx]   <= in_data.burst;
      if (in_data.burst == '0) begin
        first_run_r[ld_idx] <= {1'b0, in_data.arrival};
        finish_r[ld_idx]    <= {1'b0, in_data.arrival};
      end
    end
    if ((state_r == ST_SERVE) && found_r) begin
      rem_r[pick_r] <= best_rem_r - BURST_W'(1);
      if (!best_started_r) begin
        first_run_r[pick_r] <= sim_clk_r;
      end
      if (best_rem_r == BURST_W'(1)) begin
        finish_r[pick_r] <= sim_clk_r + TIME_W'(1);
      end
    end
    if (state_r == ST_EMIT) begin
      out_r.result_tag  <= tag_r[idx_r];
      out_r.completion  <= finish_r[idx_r];
      out_r.turnaround  <= tat;
      out_r.waiting     <= tat - {{(TIME_W-BURST_W){1'b0}}, burst_r[idx_r]};
      out_r.response    <= first_run_r[idx_r] - {1'b0, arr_r[idx_r]};
      out_r.last_result <= idx_last;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PPS_ASSERT(a_count_bound, job_count_r <= CNT_W'(MAX_JOBS), "job count above capacity")
  `PPS_ASSERT(a_fin_bound, !busy || (fin_count_r <= job_count_r), "finished count too high")
  `PPS_ASSERT_NEXT(a_emit_strobe, state_r == ST_EMIT, out_valid, "strobe missing after emit")
  `PPS_ASSERT(a_strobe_src, !out_valid || ($past(state_r) == ST_EMIT), "strobe without emit")

endmodule
